### rtl/core/i2crbm_pkg.sv
// types and constants shared by the i2c register byte master
`default_nettype none

package i2crbm_pkg;

  localparam logic [7:0] DEV_ADDR_RESET = 8'hD0;
  localparam int PHASE_W = 7;
  localparam int OFF_W   = 5;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    SEG_START   = 3'd0,
    SEG_SEND    = 3'd1,
    SEG_RACK    = 3'd2,
    SEG_RESTART = 3'd3,
    SEG_WACK    = 3'd4,
    SEG_RECV    = 3'd5,
    SEG_STOP    = 3'd6
  } seg_t;

  typedef enum logic [1:0] {
    BYTE_DEVW = 2'd0,
    BYTE_REG  = 2'd1,
    BYTE_DATA = 2'd2,
    BYTE_DEVR = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic             found;
    seg_t             seg;
    byte_sel_t        sel;
    logic [OFF_W-1:0] off;
  } plan_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rd_data;
    logic       last_ack;
  } res_t;

  // split a small offset into bit slot and position within the slot (divide by 3)
  function automatic logic [2:0] div3(input logic [OFF_W-1:0] v);
    logic [OFF_W+3:0] prod;
    prod = {4'd0, v} * 9'd11;
    return prod[OFF_W+2:OFF_W];
  endfunction

  function automatic logic [1:0] mod3(input logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] q3;
    q3 = {2'd0, div3(v)} * 5'd3;
    return 2'(v - q3);
  endfunction

endpackage

`default_nettype wire

### rtl/core/i2crbm_in_if.sv
// input channel interface: commands and tick items
`default_nettype none

interface i2crbm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] reg_addr;
  logic [7:0] wr_data;
  logic       sda_in;

  modport source (output valid, output cmd, output reg_addr, output wr_data,
                  output sda_in, input ready);
  modport sink   (input valid, input cmd, input reg_addr, input wr_data,
                  input sda_in, output ready);
endinterface

`default_nettype wire

### rtl/core/i2crbm_out_if.sv
// result channel interface: line levels and status per transfer
`default_nettype none

interface i2crbm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rd_data;
  logic       last_ack;

  modport source (output valid, output scl_level, output sda_level, output sda_drive,
                  output busy_res, output done_res, output rd_data, output last_ack,
                  input ready);
  modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
                  input busy_res, input done_res, input rd_data, input last_ack,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/i2c_register_byte_master_top.sv
// top level of the i2c register byte master
// a result is registered and appears in the cycle after its input transfer
// throughput: one item per cycle while the result side keeps up
// the state registers double as the result register, loaded only on a transfer
// reset (synchronous, active low): idle, lines high and driven, ack 1, address 0xd0
`default_nettype none

module i2c_register_byte_master_top import i2crbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  i2crbm_in_if.sink    in_ch,
  i2crbm_out_if.source out_ch
);

  logic out_valid_r, out_valid_nxt;
  logic in_xfer;
  res_t res;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  i2crbm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (in_xfer),
    .cmd       (in_ch.cmd),
    .reg_addr  (in_ch.reg_addr),
    .wr_data   (in_ch.wr_data),
    .sda_in    (in_ch.sda_in),
    .res       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_level = res.scl;
  assign out_ch.sda_level = res.sda;
  assign out_ch.sda_drive = res.drive;
  assign out_ch.busy_res  = res.busy;
  assign out_ch.done_res  = res.done;
  assign out_ch.rd_data   = res.rd_data;
  assign out_ch.last_ack  = res.last_ack;

endmodule

`default_nettype wire

### rtl/core/i2crbm_plan.sv
// phase decoder: maps the phase counter onto a bus segment and offset
`default_nettype none

module i2crbm_plan import i2crbm_pkg::*; (
  input  op_t                op,
  input  logic [PHASE_W-1:0] phase,
  output plan_t              plan
);

  logic [PHASE_W-1:0] base;
  logic [PHASE_W-1:0] rel;

  always_comb begin
    plan.found = 1'b1;
    plan.seg   = SEG_START;
    plan.sel   = BYTE_DEVW;
    base       = '0;
    case (op)
      OP_WRITE: begin
        case (phase) inside
          [7'd0:7'd2]:   begin plan.seg = SEG_START; base = 7'd0; end
          [7'd3:7'd27]:  begin plan.seg = SEG_SEND; plan.sel = BYTE_DEVW; base = 7'd3; end
          [7'd28:7'd32]: begin plan.seg = SEG_RACK; base = 7'd28; end
          [7'd33:7'd57]: begin plan.seg = SEG_SEND; plan.sel = BYTE_REG; base = 7'd33; end
          [7'd58:7'd62]: begin plan.seg = SEG_RACK; base = 7'd58; end
          [7'd63:7'd87]: begin plan.seg = SEG_SEND; plan.sel = BYTE_DATA; base = 7'd63; end
          [7'd88:7'd92]: begin plan.seg = SEG_RACK; base = 7'd88; end
          [7'd93:7'd95]: begin plan.seg = SEG_STOP; base = 7'd93; end
          default:       plan.found = 1'b0;
        endcase
      end
      OP_READ: begin
        case (phase) inside
          [7'd0:7'd2]:    begin plan.seg = SEG_START; base = 7'd0; end
          [7'd3:7'd27]:   begin plan.seg = SEG_SEND; plan.sel = BYTE_DEVW; base = 7'd3; end
          [7'd28:7'd32]:  begin plan.seg = SEG_RACK; base = 7'd28; end
          [7'd33:7'd57]:  begin plan.seg = SEG_SEND; plan.sel = BYTE_REG; base = 7'd33; end
          [7'd58:7'd62]:  begin plan.seg = SEG_RACK; base = 7'd58; end
          [7'd63:7'd66]:  begin plan.seg = SEG_RESTART; base = 7'd63; end
          [7'd67:7'd91]:  begin plan.seg = SEG_SEND; plan.sel = BYTE_DEVR; base = 7'd67; end
          [7'd92:7'd94]:  begin plan.seg = SEG_WACK; base = 7'd92; end
          [7'd95:7'd121]: begin plan.seg = SEG_RECV; base = 7'd95; end
          [7'd122:7'd124]: begin plan.seg = SEG_STOP; base = 7'd122; end
          default:        plan.found = 1'b0;
        endcase
      end
      default: plan.found = 1'b0;
    endcase
    rel      = phase - base;
    plan.off = rel[OFF_W-1:0];
  end

endmodule

`default_nettype wire

### rtl/core/i2crbm_core.sv
// transaction state, line levels and byte shifting for one phase per transfer
`default_nettype none

module i2crbm_core import i2crbm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  input  logic       step,
  input  logic [1:0] cmd,
  input  logic [7:0] reg_addr,
  input  logic [7:0] wr_data,
  input  logic       sda_in,
  output res_t       res
);

  logic [7:0]         dev_addr_r;
  op_t                op_r, op_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [7:0]         addr_r, addr_nxt;
  logic [7:0]         data_r, data_nxt;
  logic [7:0]         rd_byte_r, rd_byte_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               drv_r, drv_nxt;
  logic               ack_r, ack_nxt;
  logic               done_r, done_nxt;

  plan_t              plan;
  logic [OFF_W-1:0]   send_rel;
  logic [OFF_W-1:0]   recv_rel;
  logic [2:0]         bit_k;
  logic [1:0]         send_r;
  logic [1:0]         recv_r;
  logic [7:0]         cur_byte;

  i2crbm_plan u_plan (
    .op    (op_r),
    .phase (phase_r),
    .plan  (plan)
  );

  assign send_rel = plan.off - 5'd1;
  assign recv_rel = plan.off - 5'd2;
  assign bit_k    = div3(send_rel);
  assign send_r   = mod3(send_rel);
  assign recv_r   = mod3(recv_rel);

  always_comb begin
    case (plan.sel)
      BYTE_DEVW: cur_byte = {dev_addr_r[7:1], 1'b0};
      BYTE_REG:  cur_byte = addr_r;
      BYTE_DATA: cur_byte = data_r;
      default:   cur_byte = {dev_addr_r[7:1], 1'b1};
    endcase
  end

  always_comb begin
    op_nxt      = op_r;
    phase_nxt   = phase_r;
    shift_nxt   = shift_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    rd_byte_nxt = rd_byte_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    drv_nxt     = drv_r;
    ack_nxt     = ack_r;
    done_nxt    = done_r;
    if (step) begin
      done_nxt = 1'b0;
      case (cmd_t'(cmd))
        CMD_TICK: begin
          if (op_r != OP_IDLE) begin
            if (!plan.found) begin
              op_nxt    = OP_IDLE;
              phase_nxt = '0;
            end else begin
              phase_nxt = phase_r + 7'd1;
              case (plan.seg)
                SEG_START: begin
                  if (plan.off == 5'd0) scl_nxt = 1'b1;
                  else sda_nxt = (plan.off == 5'd1);
                end
                SEG_SEND: begin
                  if (plan.off == 5'd0) scl_nxt = 1'b0;
                  else if (send_r == 2'd0) sda_nxt = cur_byte[~bit_k];
                  else scl_nxt = (send_r == 2'd1);
                end
                SEG_RACK: begin
                  case (plan.off)
                    5'd0:    drv_nxt = 1'b0;
                    5'd1:    scl_nxt = 1'b1;
                    5'd2:    ack_nxt = sda_in;
                    5'd3:    scl_nxt = 1'b0;
                    default: drv_nxt = 1'b1;
                  endcase
                end
                SEG_RESTART: begin
                  if (plan.off == 5'd1) scl_nxt = 1'b1;
                  else sda_nxt = (plan.off != 5'd3);
                end
                SEG_WACK: begin
                  if (plan.off == 5'd0) sda_nxt = 1'b0;
                  else scl_nxt = (plan.off == 5'd1);
                end
                SEG_RECV: begin
                  if (plan.off == 5'd0) begin
                    scl_nxt   = 1'b0;
                    shift_nxt = '0;
                  end else if (plan.off == 5'd1) begin
                    drv_nxt = 1'b0;
                  end else if (plan.off == 5'd26) begin
                    drv_nxt     = 1'b1;
                    rd_byte_nxt = shift_r;
                  end else if (recv_r == 2'd0) begin
                    scl_nxt = 1'b1;
                  end else if (recv_r == 2'd1) begin
                    shift_nxt = {shift_r[6:0], sda_in};
                  end else begin
                    scl_nxt = 1'b0;
                  end
                end
                default: begin
                  if (plan.off == 5'd1) scl_nxt = 1'b1;
                  else sda_nxt = (plan.off == 5'd2);
                  // stop is always the final segment
                  if (plan.off == 5'd2) begin
                    op_nxt    = OP_IDLE;
                    phase_nxt = '0;
                    done_nxt  = 1'b1;
                  end
                end
              endcase
            end
          end
        end
        CMD_READ, CMD_WRITE: begin
          if (op_r == OP_IDLE) begin
            op_nxt    = (cmd_t'(cmd) == CMD_READ) ? OP_READ : OP_WRITE;
            phase_nxt = '0;
            addr_nxt  = reg_addr;
            data_nxt  = wr_data;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
      op_r       <= OP_IDLE;
      phase_r    <= '0;
      shift_r    <= '0;
      addr_r     <= '0;
      data_r     <= '0;
      rd_byte_r  <= '0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      drv_r      <= 1'b1;
      ack_r      <= 1'b1;
      done_r     <= 1'b0;
    end else begin
      if (cfg_we) dev_addr_r <= cfg_wdata;
      op_r      <= op_nxt;
      phase_r   <= phase_nxt;
      shift_r   <= shift_nxt;
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      rd_byte_r <= rd_byte_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      drv_r     <= drv_nxt;
      ack_r     <= ack_nxt;
      done_r    <= done_nxt;
    end
  end

  assign res.scl      = scl_r;
  assign res.sda      = sda_r;
  assign res.drive    = drv_r;
  assign res.busy     = (op_r != OP_IDLE);
  assign res.done     = done_r;
  assign res.rd_data  = rd_byte_r;
  assign res.last_ack = ack_r;

endmodule

`default_nettype wire

### rtl/core/i2crbm_checker.sv
// port-level assertions for the i2c register byte master, bound to the top level
`default_nettype none

module i2crbm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       scl_level,
  input logic       sda_level,
  input logic       sda_drive,
  input logic       busy_res,
  input logic       done_res,
  input logic [7:0] rd_data,
  input logic       last_ack
);

  // every input transfer produces a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(scl_level) && $stable(sda_level)
      && $stable(sda_drive) && $stable(busy_res) && $stable(done_res)
      && $stable(rd_data) && $stable(last_ack))
    else $error("result changed while stalled");

  // completion leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> !busy_res)
    else $error("done reported while busy");

  // a stop leaves both lines high with the data line driven
  a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> scl_level && sda_level && sda_drive)
    else $error("bus not released high after stop");

endmodule

bind i2c_register_byte_master_top i2crbm_checker u_i2crbm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .scl_level (out_ch.scl_level),
  .sda_level (out_ch.sda_level),
  .sda_drive (out_ch.sda_drive),
  .busy_res  (out_ch.busy_res),
  .done_res  (out_ch.done_res),
  .rd_data   (out_ch.rd_data),
  .last_ack  (out_ch.last_ack)
);

`default_nettype wire

### verif/tb_i2c_register_byte_master_top.sv
// testbench for the i2c register byte master: random command and tick traffic checked per phase
`timescale 1ns / 1ps

module tb_i2c_register_byte_master_top;
  import i2crbm_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         WRITE_TICKS = 96;
  localparam int         READ_TICKS  = 125;
  localparam int         STALL_LIMIT = 3000;
  localparam int         HOLD_CYCLES = 400;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         MIX_ITEMS   = 180;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } bus_item_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  i2crbm_in_if  in_ch ();
  i2crbm_out_if out_ch ();

  i2c_register_byte_master_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bus_item_t pending_items [$];
  res_t      bus_expect_q [$];
  int        src_idle_pct;
  int        sink_stall_pct;
  logic      hold_go;
  int        hold_cnt;
  int        idle_cycles;
  int        gen_busy_left;
  int        mismatch_count;
  int        results_seen;
  int        writes_done;
  int        reads_done;
  int        addr_writes;

  // bus shadow state
  op_t        bus_op;
  logic [6:0] bus_phase;
  logic [7:0] bus_shift;
  logic [7:0] bus_reg;
  logic [7:0] bus_data;
  logic [7:0] bus_rd;
  logic [7:0] dev_addr;
  logic       bus_scl;
  logic       bus_sda;
  logic       bus_drv;
  logic       bus_ack;

  bus_item_t drv_item;
  bus_item_t mon_item;
  res_t      mon_got;
  res_t      mon_want;

  function automatic int seg_span(input seg_t sg);
    case (sg)
      SEG_START:   return 3;
      SEG_SEND:    return 25;
      SEG_RACK:    return 5;
      SEG_RESTART: return 4;
      SEG_WACK:    return 3;
      SEG_RECV:    return 27;
      default:     return 3;
    endcase
  endfunction

  function automatic seg_t plan_seg(input op_t op, input int idx);
    if (op == OP_READ) begin
      case (idx)
        0:       return SEG_START;
        1, 3, 6: return SEG_SEND;
        2, 4:    return SEG_RACK;
        5:       return SEG_RESTART;
        7:       return SEG_WACK;
        8:       return SEG_RECV;
        default: return SEG_STOP;
      endcase
    end else begin
      case (idx)
        0:       return SEG_START;
        1, 3, 5: return SEG_SEND;
        2, 4, 6: return SEG_RACK;
        default: return SEG_STOP;
      endcase
    end
  endfunction

  function automatic byte_sel_t plan_byte(input op_t op, input int idx);
    case (idx)
      3:       return BYTE_REG;
      5:       return (op == OP_WRITE) ? BYTE_DATA : BYTE_DEVW;
      6:       return BYTE_DEVR;
      default: return BYTE_DEVW;
    endcase
  endfunction

  function automatic logic [7:0] tx_byte(input byte_sel_t bs);
    case (bs)
      BYTE_DEVW: return {dev_addr[7:1], 1'b0};
      BYTE_REG:  return bus_reg;
      BYTE_DATA: return bus_data;
      default:   return {dev_addr[7:1], 1'b1};
    endcase
  endfunction

  task automatic bus_phase_step(input logic sda_in, output logic stopped, output logic lost);
    int         off;
    int         idx;
    int         nseg;
    int         k;
    int         r3;
    logic       found;
    seg_t       sg;
    logic [7:0] tx;
    nseg    = (bus_op == OP_READ) ? 10 : 8;
    off     = bus_phase;
    idx     = 0;
    found   = 1'b0;
    stopped = 1'b0;
    lost    = 1'b0;
    sg      = SEG_START;
    while (!found && idx < nseg) begin
      sg = plan_seg(bus_op, idx);
      if (off < seg_span(sg)) begin
        found = 1'b1;
      end else begin
        off -= seg_span(sg);
        idx++;
      end
    end
    if (!found) begin
      lost = 1'b1;
    end else begin
      case (sg)
        SEG_START: begin
          if (off == 0) bus_scl = 1'b1;
          else bus_sda = (off == 1);
        end
        SEG_SEND: begin
          if (off == 0) begin
            bus_scl = 1'b0;
          end else begin
            k  = (off - 1) / 3;
            r3 = (off - 1) % 3;
            tx = tx_byte(plan_byte(bus_op, idx));
            if (r3 == 0) bus_sda = tx[7-k];
            else bus_scl = (r3 == 1);
          end
        end
        SEG_RACK: begin
          case (off)
            0:       bus_drv = 1'b0;
            1:       bus_scl = 1'b1;
            2:       bus_ack = sda_in;
            3:       bus_scl = 1'b0;
            default: bus_drv = 1'b1;
          endcase
        end
        SEG_RESTART: begin
          if (off == 1) bus_scl = 1'b1;
          else bus_sda = (off != 3);
        end
        SEG_WACK: begin
          if (off == 0) bus_sda = 1'b0;
          else bus_scl = (off == 1);
        end
        SEG_RECV: begin
          if (off == 0) begin
            bus_scl   = 1'b0;
            bus_shift = 8'd0;
          end else if (off == 1) begin
            bus_drv = 1'b0;
          end else if (off == 26) begin
            bus_drv = 1'b1;
            bus_rd  = bus_shift;
          end else begin
            r3 = (off - 2) % 3;
            if (r3 == 0) bus_scl = 1'b1;
            else if (r3 == 1) bus_shift = {bus_shift[6:0], sda_in};
            else bus_scl = 1'b0;
          end
        end
        default: begin
          if (off == 1) bus_scl = 1'b1;
          else bus_sda = (off == 2);
          if (off == 2 && idx == nseg - 1) stopped = 1'b1;
        end
      endcase
    end
  endtask

  task automatic predict_bus(input bus_item_t it, output res_t want);
    logic stopped;
    logic lost;
    stopped = 1'b0;
    lost    = 1'b0;
    if (it.cmd == CMD_TICK) begin
      if (bus_op != OP_IDLE) begin
        bus_phase_step(it.sda_in, stopped, lost);
        if (stopped || lost) begin
          if (stopped && bus_op == OP_READ) reads_done++;
          else if (stopped) writes_done++;
          bus_op    = OP_IDLE;
          bus_phase = 7'd0;
        end else begin
          bus_phase = bus_phase + 7'd1;
        end
      end
    end else if ((it.cmd == CMD_READ || it.cmd == CMD_WRITE) && bus_op == OP_IDLE) begin
      bus_op    = (it.cmd == CMD_READ) ? OP_READ : OP_WRITE;
      bus_phase = 7'd0;
      bus_reg   = it.reg_addr;
      bus_data  = it.wr_data;
    end
    want.scl      = bus_scl;
    want.sda      = bus_sda;
    want.drive    = bus_drv;
    want.busy     = (bus_op != OP_IDLE);
    want.done     = stopped;
    want.rd_data  = bus_rd;
    want.last_ack = bus_ack;
  endtask

  task automatic flag_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
    if (mismatch_count < 40)
      $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_item(input logic [1:0] cmd, input logic [7:0] ra, input logic [7:0] wd,
                           input logic sda);
    bus_item_t it;
    it.cmd      = cmd;
    it.reg_addr = ra;
    it.wr_data  = wd;
    it.sda_in   = sda;
    if (cmd == CMD_TICK) begin
      if (gen_busy_left != 0) gen_busy_left--;
    end else if (gen_busy_left == 0 && cmd == CMD_READ) begin
      gen_busy_left = READ_TICKS;
    end else if (gen_busy_left == 0 && cmd == CMD_WRITE) begin
      gen_busy_left = WRITE_TICKS;
    end
    pending_items.push_back(it);
  endtask

  task automatic finish_bus();
    while (gen_busy_left != 0)
      push_item(CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic queue_traffic(input int n);
    int         made;
    int         r;
    logic [1:0] cmd;
    made = 0;
    while (made < n) begin
      r = $urandom_range(99);
      if (gen_busy_left == 0) begin
        if (r < 10) cmd = CMD_TICK;
        else if (r < 14) cmd = CMD_UNUSED;
        else if (r < 57) cmd = CMD_READ;
        else cmd = CMD_WRITE;
      end else begin
        // commands while busy must be dropped
        if (r < 2) cmd = CMD_READ;
        else if (r < 4) cmd = CMD_WRITE;
        else if (r < 6) cmd = CMD_UNUSED;
        else cmd = CMD_TICK;
      end
      push_item(cmd, 8'($urandom), 8'($urandom), 1'($urandom));
      made++;
    end
    finish_bus();
  endtask

  // sampled away from the rising edge so the sender's updates have settled
  task automatic wait_drained();
    @(negedge clk);
    while (pending_items.size() != 0 || in_ch.valid || bus_expect_q.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_dev_addr(input logic [7:0] v);
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    addr_writes++;
  endtask

  task automatic run_mix(input int src_pct, input int sink_pct, input int n);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    queue_traffic(n);
    wait_drained();
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item = pending_items.pop_front();
        in_ch.cmd      <= drv_item.cmd;
        in_ch.reg_addr <= drv_item.reg_addr;
        in_ch.wr_data  <= drv_item.wr_data;
        in_ch.sda_in   <= drv_item.sda_in;
        in_ch.valid    <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go) begin
      hold_cnt <= HOLD_CYCLES;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_cnt == 0) && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // monitor: check each result transfer, then predict from each input transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        mon_got.scl      = out_ch.scl_level;
        mon_got.sda      = out_ch.sda_level;
        mon_got.drive    = out_ch.sda_drive;
        mon_got.busy     = out_ch.busy_res;
        mon_got.done     = out_ch.done_res;
        mon_got.rd_data  = out_ch.rd_data;
        mon_got.last_ack = out_ch.last_ack;
        if (bus_expect_q.size() == 0) begin
          flag_mismatch("result with nothing pending", 8'd0, 8'd0);
        end else begin
          mon_want = bus_expect_q.pop_front();
          if (mon_got.scl !== mon_want.scl)
            flag_mismatch("scl_level", 8'(mon_got.scl), 8'(mon_want.scl));
          if (mon_got.sda !== mon_want.sda)
            flag_mismatch("sda_level", 8'(mon_got.sda), 8'(mon_want.sda));
          if (mon_got.drive !== mon_want.drive)
            flag_mismatch("sda_drive", 8'(mon_got.drive), 8'(mon_want.drive));
          if (mon_got.busy !== mon_want.busy)
            flag_mismatch("busy_res", 8'(mon_got.busy), 8'(mon_want.busy));
          if (mon_got.done !== mon_want.done)
            flag_mismatch("done_res", 8'(mon_got.done), 8'(mon_want.done));
          if (mon_got.rd_data !== mon_want.rd_data)
            flag_mismatch("rd_data", mon_got.rd_data, mon_want.rd_data);
          if (mon_got.last_ack !== mon_want.last_ack)
            flag_mismatch("last_ack", 8'(mon_got.last_ack), 8'(mon_want.last_ack));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        mon_item.cmd      = in_ch.cmd;
        mon_item.reg_addr = in_ch.reg_addr;
        mon_item.wr_data  = in_ch.wr_data;
        mon_item.sda_in   = in_ch.sda_in;
        predict_bus(mon_item, mon_want);
        bus_expect_q.push_back(mon_want);
      end
      if (cfg_we) dev_addr = cfg_wdata;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = 8'd0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_TICK;
    in_ch.reg_addr = 8'd0;
    in_ch.wr_data  = 8'd0;
    in_ch.sda_in   = 1'b0;
    out_ch.ready   = 1'b0;
    hold_go        = 1'b0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    gen_busy_left  = 0;
    mismatch_count = 0;
    results_seen   = 0;
    writes_done    = 0;
    reads_done     = 0;
    addr_writes    = 0;
    idle_cycles    = 0;
    bus_op         = OP_IDLE;
    bus_phase      = 7'd0;
    bus_shift      = 8'd0;
    bus_reg        = 8'd0;
    bus_data       = 8'd0;
    bus_rd         = 8'd0;
    dev_addr       = DEV_ADDR_RESET;
    bus_scl        = 1'b1;
    bus_sda        = 1'b1;
    bus_drv        = 1'b1;
    bus_ack        = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // idle tick, unused command, then a write and reads with extreme operands
    push_item(CMD_TICK, 8'h00, 8'h00, 1'b0);
    push_item(CMD_UNUSED, 8'hff, 8'hff, 1'b1);
    push_item(CMD_WRITE, 8'hff, 8'h00, 1'b0);
    push_item(CMD_READ, 8'h00, 8'hff, 1'b1);
    push_item(CMD_UNUSED, 8'h5a, 8'ha5, 1'b0);
    for (i = 0; i < WRITE_TICKS; i++) push_item(CMD_TICK, 8'h00, 8'h00, 1'(i));
    push_item(CMD_TICK, 8'hff, 8'hff, 1'b1);
    push_item(CMD_READ, 8'h00, 8'hff, 1'b1);
    push_item(CMD_WRITE, 8'hff, 8'h00, 1'b0);
    for (i = 0; i < READ_TICKS; i++) push_item(CMD_TICK, 8'h00, 8'h00, 1'b1);
    push_item(CMD_READ, 8'hff, 8'h00, 1'b0);
    for (i = 0; i < READ_TICKS; i++) push_item(CMD_TICK, 8'hff, 8'hff, 1'b0);
    push_item(CMD_WRITE, 8'h00, 8'hff, 1'b1);
    for (i = 0; i < WRITE_TICKS; i++) push_item(CMD_TICK, 8'hff, 8'h00, 1'b1);
    wait_drained();

    run_mix(0, 0, MIX_ITEMS);
    write_dev_addr(8'h00);
    run_mix(58, 0, MIX_ITEMS);
    write_dev_addr(8'hff);
    run_mix(0, 58, MIX_ITEMS);
    write_dev_addr(8'($urandom));
    run_mix(27, 27, MIX_ITEMS);
    write_dev_addr(8'($urandom));

    // receiver holds off while the sender keeps offering
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    queue_traffic(MIX_ITEMS);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results over %0d register writes and %0d register reads",
             results_seen, writes_done, reads_done);
    $display("device address reprogrammed %0d times, random idling on both sides",
             addr_writes);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
